FILE: src/mhe_pkg.sv
// ============================================================================
// mhe_pkg
// Shared types, codes and controller/datapath interface structs for the
// binary max-heap extract block.
// ============================================================================
`default_nettype none

package mhe_pkg;

    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 16;

    // Operation codes carried in the func field.
    localparam logic FUNC_APPEND  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [1:0]               status;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // Item accepted this cycle.
        logic rd_last;   // Capture the root, read the last element, shrink.
        logic ld_last;   // Load the moving element, restart at the root.
        logic rd_left;   // Read the left child of the current node.
        logic rd_right;  // Capture the left child, read the right child.
        logic descend;   // Move the larger child up and step down to it.
        logic settle;    // Write the moving element and post the result.
    } mhe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic is_empty;
        logic has_left;
        logic child_wins;
    } mhe_stat_t;

endpackage

`default_nettype wire

FILE: src/mhe_ram.sv
// ============================================================================
// mhe_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module mhe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/mhe_datapath.sv
// ============================================================================
// mhe_datapath
// Heap store, element count, sift-down registers and the result register.
// ============================================================================
`default_nettype none

module mhe_datapath #(
    parameter int DEPTH = mhe_pkg::DEFAULT_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mhe_pkg::mhe_cmd_t cmd,
    output mhe_pkg::mhe_stat_t     stat,
    input  wire mhe_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output mhe_pkg::result_t       result
);
    import mhe_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        node_reg, node_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] left_val_reg, left_val_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rdata_s;

    logic [IDX_W-1:0]         count_ext;
    logic [IDX_W-1:0]         left_idx;
    logic [IDX_W-1:0]         right_idx;
    logic                     has_right;
    logic                     pick_right;
    logic [IDX_W-1:0]         child_idx;
    logic signed [DATA_W-1:0] child_val;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_W-1:0]         last_idx;

    mhe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rdata_s   = ram_rdata;
    assign count_ext = IDX_W'(count_reg);
    assign left_idx  = {1'b0, node_reg, 1'b1};
    assign right_idx = {1'b0, node_reg, 1'b0} + IDX_W'(2);
    assign has_right = right_idx < count_ext;
    assign is_full   = count_reg == FULL_COUNT;
    assign is_empty  = count_reg == '0;
    assign last_idx  = count_reg - CNT_W'(1);

    // Larger child; on a tie the left one is kept.
    assign pick_right = has_right && (rdata_s > left_val_reg);
    assign child_idx  = pick_right ? right_idx : left_idx;
    assign child_val  = pick_right ? rdata_s : left_val_reg;

    assign stat.out_free   = !out_valid_reg || result_ready;
    assign stat.is_empty   = is_empty;
    assign stat.has_left   = left_idx < count_ext;
    assign stat.child_wins = child_val > val_reg;

    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_wdata      = val_reg;
        ram_raddr      = '0;
        count_next     = count_reg;
        node_next      = node_reg;
        val_next       = val_reg;
        max_next       = max_reg;
        left_val_next  = left_val_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;

        if (cmd.start)
        begin
            if (item.func == FUNC_APPEND)
            begin
                out_valid_next     = 1'b1;
                out_next.max_value = '0;
                if (is_full)
                begin
                    out_next.status = STATUS_FULL;
                end
                else
                begin
                    out_next.status = STATUS_OK;
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[ADDR_W-1:0];
                    ram_wdata       = item.value;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            else if (is_empty)
            begin
                out_valid_next     = 1'b1;
                out_next.max_value = '0;
                out_next.status    = STATUS_EMPTY;
            end
        end

        if (cmd.rd_last)
        begin
            max_next   = rdata_s;
            ram_raddr  = last_idx[ADDR_W-1:0];
            count_next = last_idx;
        end

        if (cmd.ld_last)
        begin
            val_next  = rdata_s;
            node_next = '0;
        end

        if (cmd.rd_left)
        begin
            ram_raddr = left_idx[ADDR_W-1:0];
        end

        if (cmd.rd_right)
        begin
            left_val_next = rdata_s;
            ram_raddr     = right_idx[ADDR_W-1:0];
        end

        if (cmd.descend)
        begin
            ram_we    = 1'b1;
            ram_waddr = node_reg;
            ram_wdata = child_val;
            node_next = child_idx[ADDR_W-1:0];
        end

        if (cmd.settle)
        begin
            ram_we             = 1'b1;
            ram_waddr          = node_reg;
            ram_wdata          = val_reg;
            out_valid_next     = 1'b1;
            out_next.max_value = max_reg;
            out_next.status    = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        val_reg      <= val_next;
        max_reg      <= max_next;
        left_val_reg <= left_val_next;
        out_reg      <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: src/mhe_ctrl.sv
// ============================================================================
// mhe_ctrl
// Sequencer for append, extract and the level-by-level sift-down.
// ============================================================================
`default_nettype none

module mhe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic               item_func,
    input  wire mhe_pkg::mhe_stat_t stat,
    output mhe_pkg::mhe_cmd_t       cmd
);
    import mhe_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD_LAST  = 6'b000010,
        ST_LD_LAST  = 6'b000100,
        ST_CHECK    = 6'b001000,
        ST_RD_RIGHT = 6'b010000,
        ST_CMP      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign item_ready = (state_reg == ST_IDLE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    cmd.start = 1'b1;
                    if (item_func == FUNC_EXTRACT && !stat.is_empty)
                    begin
                        state_next = ST_RD_LAST;
                    end
                end
            end
            ST_RD_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = ST_LD_LAST;
            end
            ST_LD_LAST:
            begin
                cmd.ld_last = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.has_left)
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = ST_RD_RIGHT;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_RIGHT:
            begin
                cmd.rd_right = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.child_wins)
                begin
                    cmd.descend = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/max_heap_extract.sv
// ============================================================================
// max_heap_extract
// Binary max-heap of signed 32-bit values with append and extract-max.
// ============================================================================
// Each input beat is either an append or an extract, and each produces
// exactly one result beat. An append takes one cycle: the value is written
// at the next free slot without any reordering, so the caller is expected
// to load values that already form a valid heap. An extract returns the root
// and sifts the former last element down from the root, by at most log2
// of DEPTH levels. Each level is paced by the single read port of the
// heap store: it reads the left and the right child one after the other,
// and the registered read output feeds the compare. Extract from an empty
// heap reports an empty status and append to a full store reports a full
// status, both without changing the heap.
// A finished result waits in an output register, and the next beat is taken
// in the same cycle that the previous result is taken.
`default_nettype none

module max_heap_extract #(
    parameter int DEPTH = mhe_pkg::DEFAULT_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mhe_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mhe_pkg::result_t      result
);
    import mhe_pkg::*;

    // Command and status buses between the sequencer and the datapath.
    mhe_cmd_t  cmd;
    mhe_stat_t stat;

    // The sequencer walks the sift-down one level at a time: read left child,
    // read right child, compare, then move the larger child up or settle the
    // moving element in place. A node without a left child settles at once.
    mhe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_func  (item.func),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath owns the heap store, the element count, the moving
    // element and the result register.
    mhe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: sim/max_heap_extract_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// max_heap_extract_tb
// Self-checking bench for the max-heap append / extract-max block. A short
// scripted sequence hits empty and full heaps, extreme values and tied
// children. A long random run then fills and drains the heap with mostly
// heap-ordered appends. Every result beat is checked against a scripted
// value or against a behavioral copy of the heap kept inside the bench.
// ============================================================================

module max_heap_extract_tb;

    import mhe_pkg::*;

    localparam int HEAP_DEPTH = DEFAULT_DEPTH;
    localparam int RANDOM_BEATS = 1400;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

    // One row of the scripted sequence. A row with a known result carries
    // it directly; every other row is checked against the heap copy.
    typedef struct {
        logic                     func;
        logic signed [DATA_W-1:0] value;
        bit                       has_known;
        result_t                  known;
    } heap_step_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Bench copy of the heap store and its element count.
    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int                       heap_count = 0;

    // Results predicted for accepted beats, oldest first.
    result_t    pending_results [$];
    heap_step_t heap_script [$];

    int mismatch_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int appends_ok = 0;
    int extracts_ok = 0;
    int empty_hits = 0;
    int full_hits = 0;
    int burst_left = 0;

    max_heap_extract DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #6_000_000;
        $display("max_heap_extract_tb NOT OK");
        $finish;
    end

    // Applies one beat to the heap copy and returns the result it yields.
    // Extract moves the last element to the root and sifts it down, taking
    // the left child on a tie and never swapping with an equal child.
    function automatic result_t apply_heap_op(item_t beat);
        result_t                  res;
        int                       node;
        int                       best;
        bit                       done;
        logic signed [DATA_W-1:0] held;
        res.max_value = '0;
        res.status = STATUS_OK;
        if (beat.func == FUNC_APPEND)
        begin
            if (heap_count >= HEAP_DEPTH)
            begin
                res.status = STATUS_FULL;
                full_hits++;
            end
            else
            begin
                heap_mem[heap_count] = beat.value;
                heap_count++;
                appends_ok++;
            end
        end
        else if (heap_count == 0)
        begin
            res.status = STATUS_EMPTY;
            empty_hits++;
        end
        else
        begin
            res.max_value = heap_mem[0];
            heap_mem[0] = heap_mem[heap_count - 1];
            heap_count--;
            extracts_ok++;
            node = 0;
            done = 1'b0;
            while (!done)
            begin
                best = node;
                if (2 * node + 1 < heap_count && heap_mem[2 * node + 1] > heap_mem[best])
                    best = 2 * node + 1;
                if (2 * node + 2 < heap_count && heap_mem[2 * node + 2] > heap_mem[best])
                    best = 2 * node + 2;
                if (best == node)
                    done = 1'b1;
                else
                begin
                    held = heap_mem[node];
                    heap_mem[node] = heap_mem[best];
                    heap_mem[best] = held;
                    node = best;
                end
            end
        end
        return res;
    endfunction

    // Picks an append value. Most of the time it is no larger than the
    // parent of the next free slot, so the heap stays well ordered; a few
    // percent are arbitrary words that break the ordering on purpose.
    function automatic logic signed [DATA_W-1:0] pick_append_value();
        int     roll;
        longint parent;
        longint span;
        longint offset;
        roll = $urandom_range(0, 99);
        if (heap_count == 0)
            return (roll < 10) ? VAL_MAX : $urandom;
        if (roll < 8)
            return $urandom;
        parent = heap_mem[(heap_count - 1) / 2];
        if (roll < 22)
            return DATA_W'(parent);
        if (roll < 27)
            return VAL_MIN;
        if (roll < 60)
        begin
            offset = $urandom_range(0, 8);
            return (parent - offset < longint'(VAL_MIN)) ? VAL_MIN
                                                         : DATA_W'(parent - offset);
        end
        span = parent - longint'(VAL_MIN);
        offset = longint'({$urandom, $urandom} % (span + 1));
        return DATA_W'(parent - offset);
    endfunction

    function automatic void add_step(logic func, logic signed [DATA_W-1:0] value,
                                     bit has_known, logic signed [DATA_W-1:0] known_max,
                                     logic [1:0] known_status);
        heap_step_t row;
        row.func = func;
        row.value = value;
        row.has_known = has_known;
        row.known.max_value = known_max;
        row.known.status = known_status;
        heap_script.push_back(row);
    endfunction

    // Presents one beat, holds it until it is taken, then records the
    // result that the beat must produce. The sender runs in bursts; when a
    // burst runs out, valid drops for a random gap before the next beat.
    task automatic send_beat(input logic func, input logic signed [DATA_W-1:0] value,
                             input bit has_known, input result_t known);
        item_t   beat;
        result_t predicted;
        beat.func = func;
        beat.value = value;
        @(negedge clk);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 5);
        end
        item_valid <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = apply_heap_op(beat);
        pending_results.push_back(has_known ? known : predicted);
        beats_sent++;
        burst_left--;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: switches between always ready, coin-flip ready, a fixed
    // one-in-three pattern and long stalls with rare ready cycles.
    initial
    begin : result_sink
        int mode;
        int span_len;
        int tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span_len = $urandom_range(10, 80);
            repeat (span_len)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 1) == 1);
                    2: result_ready <= (tick % 3 == 0);
                    default: result_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Result checker: every accepted result beat is compared with the
    // oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: max_value %0d status %0d",
                       result.max_value, result.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.max_value !== want.max_value)
                begin
                    $error("max_value mismatch: expected %0d, actual %0d",
                           want.max_value, result.max_value);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic                     func;
        logic signed [DATA_W-1:0] value;
        bit                       filling;
        int                       fill_goal;
        int                       drain_goal;
        int                       roll;
        int                       deepest;
        heap_step_t               row;

        for (int i = 0; i < HEAP_DEPTH; i++)
            heap_mem[i] = '0;

        // Scripted part. An extract on the empty heap first, then the two
        // extremes around zero are loaded in heap order and pulled back out,
        // which forces a swap with the left child. Then the store is filled
        // with a heap full of ties and one more append must report full.
        add_step(FUNC_EXTRACT, 32'sd12345, 1'b1, '0, STATUS_EMPTY);
        add_step(FUNC_APPEND, VAL_MAX, 1'b1, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd0, 1'b1, '0, STATUS_OK);
        add_step(FUNC_APPEND, VAL_MIN, 1'b1, '0, STATUS_OK);
        add_step(FUNC_EXTRACT, VAL_MIN, 1'b1, VAL_MAX, STATUS_OK);
        add_step(FUNC_EXTRACT, VAL_MAX, 1'b1, 32'sd0, STATUS_OK);
        add_step(FUNC_EXTRACT, 32'sd0, 1'b1, VAL_MIN, STATUS_OK);
        add_step(FUNC_EXTRACT, '1, 1'b1, '0, STATUS_EMPTY);
        add_step(FUNC_APPEND, 32'sh55555555, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd40, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd40, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd40, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd7, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd40, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd40, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, -32'sd1, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, -32'sd1, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd7, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd7, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'shAAAAAAAA, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd0, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd0, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, 32'sd3, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, VAL_MIN, 1'b0, '0, STATUS_OK);
        add_step(FUNC_APPEND, VAL_MAX, 1'b1, '0, STATUS_FULL);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (heap_script[i])
        begin
            row = heap_script[i];
            send_beat(row.func, row.value, row.has_known, row.known);
        end

        // Let everything settle once before the random traffic starts.
        drain_results();

        // Random part: alternate fill and drain phases toward random target
        // counts, so the heap sweeps between empty and full. A minority of
        // beats go against the current phase, which is what produces the
        // empty and full status cases.
        filling = 1'b0;
        drain_goal = 0;
        fill_goal = HEAP_DEPTH;
        deepest = heap_count;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
                drain_results();
            if (filling && heap_count >= fill_goal)
            begin
                filling = 1'b0;
                drain_goal = ($urandom_range(0, 2) == 0 || heap_count == 0)
                             ? 0 : $urandom_range(0, heap_count - 1);
            end
            else if (!filling && heap_count <= drain_goal)
            begin
                filling = 1'b1;
                fill_goal = ($urandom_range(0, 2) == 0 || heap_count >= HEAP_DEPTH - 1)
                            ? HEAP_DEPTH : $urandom_range(heap_count + 1, HEAP_DEPTH);
            end
            roll = $urandom_range(0, 99);
            func = ((roll < 85) == filling) ? FUNC_APPEND : FUNC_EXTRACT;
            value = (func == FUNC_APPEND) ? pick_append_value() : $urandom;
            send_beat(func, value, 1'b0, '0);
            if (heap_count > deepest)
                deepest = heap_count;
        end

        // Wait out the tail, then give the block time to show any stray beat.
        drain_results();
        repeat (40) @(posedge clk);

        $display("Ran %0d beats and checked %0d results, heap reached %0d of %0d entries.",
                 beats_sent, results_seen, deepest, HEAP_DEPTH);
        $display("Appends %0d, extracts %0d, extracts on empty %0d, appends when full %0d.",
                 appends_ok, extracts_ok, empty_hits, full_hits);
        if (mismatch_count == 0)
            $display("max_heap_extract_tb OK");
        else
            $display("max_heap_extract_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/mhe_pkg.sv
src/mhe_ram.sv
src/mhe_datapath.sv
src/mhe_ctrl.sv
src/max_heap_extract.sv
sim/max_heap_extract_tb.sv
